>>> rtl/stsp_pkg.sv
// Package for the string-table stream parser: item and result types, result
// group type, phase codes, result kinds, status codes and file constants.
// Depends on nothing; used by every module of the parser.
package stsp_pkg;

   // Item taken in on the request channel.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_file;
   } stsp_req_type;

   // Result item given out on the response channel.
   typedef struct packed {
      logic [2:0] out_kind;
      logic [7:0] out_byte;
      logic [2:0] file_status;
      logic       last_of_run;
   } stsp_rsp_type;

   // Most results that one input byte can cause.
   localparam int GROUP_MAX = 5;

   // All results caused by one input byte, in order.
   typedef struct packed {
      logic [2:0]                   count;
      stsp_rsp_type [GROUP_MAX-1:0] entry;
   } stsp_group_type;

   // Parser phases.
   localparam logic [3:0] PH_FILE  = 4'd0;
   localparam logic [3:0] PH_LABEL = 4'd1;
   localparam logic [3:0] PH_NAME  = 4'd2;
   localparam logic [3:0] PH_PAIR  = 4'd3;
   localparam logic [3:0] PH_TEXT  = 4'd4;
   localparam logic [3:0] PH_XLEN  = 4'd5;
   localparam logic [3:0] PH_XTRA  = 4'd6;
   localparam logic [3:0] PH_TAIL  = 4'd7;
   localparam logic [3:0] PH_ERR   = 4'd8;

   // Result kinds.
   localparam logic [2:0] KIND_NAME_BYTE  = 3'd0;
   localparam logic [2:0] KIND_NAME_END   = 3'd1;
   localparam logic [2:0] KIND_VALUE_BYTE = 3'd2;
   localparam logic [2:0] KIND_VALUE_END  = 3'd3;
   localparam logic [2:0] KIND_STATUS     = 3'd4;

   // File status codes.
   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_SHORT_HDR   = 3'd1;
   localparam logic [2:0] ST_BAD_FILE    = 3'd2;
   localparam logic [2:0] ST_BAD_LABEL   = 3'd3;
   localparam logic [2:0] ST_BAD_MARKER  = 3'd4;
   localparam logic [2:0] ST_TRUNCATED   = 3'd5;
   localparam logic [2:0] ST_NO_LABELS   = 3'd6;

   // File format constants.
   localparam logic [31:0] FILE_MAGIC  = 32'h4353_4620;
   localparam logic [31:0] LABEL_MAGIC = 32'h4C42_4C20;
   localparam logic [31:0] MARK_PLAIN  = 32'h5354_5220;
   localparam logic [31:0] MARK_WIDE   = 32'h5354_5257;
   localparam logic [4:0]  FILE_HDR_LAST = 5'd23;

   function automatic stsp_rsp_type make_rsp(input logic [2:0] kind,
                                             input logic [7:0] data,
                                             input logic [2:0] status);
      stsp_rsp_type r;
      r.out_kind    = kind;
      r.out_byte    = data;
      r.file_status = status;
      r.last_of_run = 1'b0;
      return r;
   endfunction

endpackage

>>> rtl/stsp_parser.sv
// Parser state and per-byte decode: turns one accepted byte into a group of
// up to five results and the next parser state.
// Depends on stsp_pkg.
module stsp_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  stsp_pkg::stsp_req_type item,
   output stsp_pkg::stsp_group_type group
);
   import stsp_pkg::*;

   logic [3:0]  phase_ff,  phase_in;
   logic [4:0]  hc_ff,     hc_in;
   logic        odd_ff,    odd_in;
   logic [31:0] word_ff,   word_in;
   logic [31:0] labels_ff, labels_in;
   logic [31:0] pairs_ff,  pairs_in;
   logic [31:0] length_ff, length_in;
   logic [7:0]  low_ff,    low_in;
   logic        wide_ff,   wide_in;
   logic        stop_ff,   stop_in;
   logic        seen_ff,   seen_in;
   logic [2:0]  err_ff,    err_in;

   logic [31:0] word_new;
   logic [7:0]  b;

   assign b        = item.data_byte;
   assign word_new = {b, word_ff[31:8]};

   always_comb begin
      logic [2:0]  n;
      logic [2:0]  st;
      logic [15:0] cp;
      logic        do_name_end;
      logic        do_text_end;
      logic        do_pair_done;
      logic        do_label_done;

      n             = 3'd0;
      st            = ST_OK;
      cp            = {~b, ~low_ff};
      do_name_end   = 1'b0;
      do_text_end   = 1'b0;
      do_pair_done  = 1'b0;
      do_label_done = 1'b0;
      group         = '0;

      phase_in  = phase_ff;
      hc_in     = hc_ff;
      odd_in    = odd_ff;
      word_in   = word_ff;
      labels_in = labels_ff;
      pairs_in  = pairs_ff;
      length_in = length_ff;
      low_in    = low_ff;
      wide_in   = wide_ff;
      stop_in   = stop_ff;
      seen_in   = seen_ff;
      err_in    = err_ff;

      case (phase_ff)
         PH_FILE: begin
            word_in = word_new;
            if (hc_ff == 5'd3 && word_new != FILE_MAGIC) begin
               err_in = ST_BAD_FILE;
            end
            if (hc_ff == 5'd11) begin
               labels_in = word_new;
            end
            if (hc_ff == FILE_HDR_LAST) begin
               hc_in = 5'd0;
               if (err_ff != ST_OK) begin
                  phase_in = PH_ERR;
               end else begin
                  phase_in = (labels_ff == 32'd0) ? PH_TAIL : PH_LABEL;
               end
            end else begin
               hc_in = hc_ff + 5'd1;
            end
         end
         PH_LABEL: begin
            word_in = word_new;
            if (hc_ff == 5'd3 && word_new != LABEL_MAGIC && err_ff == ST_OK) begin
               err_in = ST_BAD_LABEL;
            end
            if (hc_ff == 5'd7) begin
               pairs_in = word_new;
            end
            if (hc_ff == 5'd11) begin
               length_in = word_new;
               hc_in     = 5'd0;
               if (err_ff != ST_OK) begin
                  phase_in = PH_ERR;
               end else begin
                  stop_in = 1'b0;
                  if (word_new == 32'd0) begin
                     do_name_end = 1'b1;
                  end else begin
                     phase_in = PH_NAME;
                  end
               end
            end else begin
               hc_in = hc_ff + 5'd1;
            end
         end
         PH_NAME: begin
            if (!stop_ff) begin
               if (b == 8'd0) begin
                  stop_in = 1'b1;
               end else begin
                  group.entry[n] = make_rsp(KIND_NAME_BYTE,
                     (b inside {[8'h41:8'h5A]}) ? b + 8'h20 : b, ST_OK);
                  n = n + 3'd1;
               end
            end
            length_in = length_ff - 32'd1;
            if (length_ff == 32'd1) begin
               do_name_end = 1'b1;
            end
         end
         PH_PAIR: begin
            word_in = word_new;
            if (hc_ff == 5'd3) begin
               if (word_new == MARK_PLAIN) begin
                  wide_in = 1'b0;
               end else if (word_new == MARK_WIDE) begin
                  wide_in = 1'b1;
               end else if (err_ff == ST_OK) begin
                  err_in = ST_BAD_MARKER;
               end
            end
            if (hc_ff == 5'd7) begin
               length_in = word_new;
               hc_in     = 5'd0;
               if (err_ff != ST_OK) begin
                  phase_in = PH_ERR;
               end else begin
                  stop_in = 1'b0;
                  odd_in  = 1'b0;
                  if (word_new == 32'd0) begin
                     do_text_end = 1'b1;
                  end else begin
                     phase_in = PH_TEXT;
                  end
               end
            end else begin
               hc_in = hc_ff + 5'd1;
            end
         end
         PH_TEXT: begin
            if (!odd_ff) begin
               low_in = b;
               odd_in = 1'b1;
            end else begin
               odd_in = 1'b0;
               if (!stop_ff) begin
                  if (cp == 16'd0) begin
                     stop_in = 1'b1;
                  end else if (cp < 16'h0080) begin
                     group.entry[n] = make_rsp(KIND_VALUE_BYTE, cp[7:0], ST_OK);
                     n = n + 3'd1;
                  end else if (cp < 16'h0800) begin
                     group.entry[n] = make_rsp(KIND_VALUE_BYTE,
                                               {3'b110, cp[10:6]}, ST_OK);
                     n = n + 3'd1;
                     group.entry[n] = make_rsp(KIND_VALUE_BYTE,
                                               {2'b10, cp[5:0]}, ST_OK);
                     n = n + 3'd1;
                  end else begin
                     group.entry[n] = make_rsp(KIND_VALUE_BYTE,
                                               {4'b1110, cp[15:12]}, ST_OK);
                     n = n + 3'd1;
                     group.entry[n] = make_rsp(KIND_VALUE_BYTE,
                                               {2'b10, cp[11:6]}, ST_OK);
                     n = n + 3'd1;
                     group.entry[n] = make_rsp(KIND_VALUE_BYTE,
                                               {2'b10, cp[5:0]}, ST_OK);
                     n = n + 3'd1;
                  end
               end
               length_in = length_ff - 32'd1;
               if (length_ff == 32'd1) begin
                  do_text_end = 1'b1;
               end
            end
         end
         PH_XLEN: begin
            word_in = word_new;
            if (hc_ff == 5'd3) begin
               length_in = word_new;
               hc_in     = 5'd0;
               if (word_new == 32'd0) begin
                  do_pair_done = 1'b1;
               end else begin
                  phase_in = PH_XTRA;
               end
            end else begin
               hc_in = hc_ff + 5'd1;
            end
         end
         PH_XTRA: begin
            length_in = length_ff - 32'd1;
            if (length_ff == 32'd1) begin
               do_pair_done = 1'b1;
            end
         end
         default: begin
         end
      endcase

      if (do_text_end) begin
         group.entry[n] = make_rsp(KIND_VALUE_END, 8'd0, ST_OK);
         n     = n + 3'd1;
         hc_in = 5'd0;
         if (wide_ff) begin
            phase_in = PH_XLEN;
         end else begin
            do_pair_done = 1'b1;
         end
      end

      if (do_name_end) begin
         group.entry[n] = make_rsp(KIND_NAME_END, 8'd0, ST_OK);
         n       = n + 3'd1;
         seen_in = 1'b1;
         hc_in   = 5'd0;
         if (pairs_in == 32'd0) begin
            do_label_done = 1'b1;
         end else begin
            phase_in = PH_PAIR;
         end
      end

      // Pair and label counts are never zero here, so a count of one means
      // this was the last.
      if (do_pair_done) begin
         pairs_in = pairs_ff - 32'd1;
         hc_in    = 5'd0;
         if (pairs_ff == 32'd1) begin
            do_label_done = 1'b1;
         end else begin
            phase_in = PH_PAIR;
         end
      end

      if (do_label_done) begin
         labels_in = labels_ff - 32'd1;
         hc_in     = 5'd0;
         phase_in  = (labels_ff == 32'd1) ? PH_TAIL : PH_LABEL;
      end

      if (item.end_of_file) begin
         case (phase_in)
            PH_ERR:  st = err_in;
            PH_FILE: st = ST_SHORT_HDR;
            PH_NAME, PH_TEXT, PH_XLEN, PH_XTRA: st = ST_TRUNCATED;
            default: st = seen_in ? ST_OK : ST_NO_LABELS;
         endcase
         group.entry[n] = make_rsp(KIND_STATUS, 8'd0, st);
         n = n + 3'd1;

         phase_in  = PH_FILE;
         hc_in     = 5'd0;
         odd_in    = 1'b0;
         word_in   = 32'd0;
         labels_in = 32'd0;
         pairs_in  = 32'd0;
         length_in = 32'd0;
         low_in    = 8'd0;
         wide_in   = 1'b0;
         stop_in   = 1'b0;
         seen_in   = 1'b0;
         err_in    = ST_OK;
      end

      group.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_FILE;
         hc_ff     <= 5'd0;
         odd_ff    <= 1'b0;
         word_ff   <= 32'd0;
         labels_ff <= 32'd0;
         pairs_ff  <= 32'd0;
         length_ff <= 32'd0;
         low_ff    <= 8'd0;
         wide_ff   <= 1'b0;
         stop_ff   <= 1'b0;
         seen_ff   <= 1'b0;
         err_ff    <= ST_OK;
      end else if (accept) begin
         phase_ff  <= phase_in;
         hc_ff     <= hc_in;
         odd_ff    <= odd_in;
         word_ff   <= word_in;
         labels_ff <= labels_in;
         pairs_ff  <= pairs_in;
         length_ff <= length_in;
         low_ff    <= low_in;
         wide_ff   <= wide_in;
         stop_ff   <= stop_in;
         seen_ff   <= seen_in;
         err_ff    <= err_in;
      end
   end

endmodule

>>> rtl/stsp_result_queue.sv
// Two-deep queue of result groups; hands out one result per cycle while not
// stalled, and marks the last result of each group.
// Depends on stsp_pkg.
module stsp_result_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  stsp_pkg::stsp_group_type group,
   output logic                     full,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output stsp_pkg::stsp_rsp_type   rsp_item
);
   import stsp_pkg::*;

   stsp_group_type slot_ff [2];
   logic [1:0]     vld_ff, vld_in;
   logic           wr_ff, wr_in;
   logic           rd_ff, rd_in;
   logic [2:0]     idx_ff, idx_in;

   stsp_group_type head;
   logic           last;

   assign head      = slot_ff[rd_ff];
   assign full      = vld_ff[0] & vld_ff[1];
   assign rsp_valid = vld_ff[rd_ff];
   assign last      = (idx_ff == head.count - 3'd1);

   always_comb begin
      rsp_item             = head.entry[idx_ff];
      rsp_item.last_of_run = last;
   end

   always_comb begin
      vld_in = vld_ff;
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      idx_in = idx_ff;
      if (push) begin
         vld_in[wr_ff] = 1'b1;
         wr_in         = ~wr_ff;
      end
      if (rsp_valid && !rsp_stall) begin
         if (last) begin
            vld_in[rd_ff] = 1'b0;
            rd_in         = ~rd_ff;
            idx_in        = 3'd0;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 2'b00;
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         idx_ff <= 3'd0;
      end else begin
         vld_ff <= vld_in;
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         idx_ff <= idx_in;
      end
   end

   // Pushes only go to a free slot, so the slot being read out is never overwritten.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= group;
      end
   end

endmodule

>>> rtl/string_table_stream_parser.sv
// String-table stream parser: one file byte per item in; name bytes, UTF-8 value bytes,
// end markers and a file status out. Depends on stsp_pkg, stsp_parser, stsp_result_queue.
// With the queue empty, an item's first result is offered the cycle after it is
// accepted. Throughput: one item per cycle while the two-group result queue has room; an
// item causes at most five results, which are given out in order.
// Reset (synchronous) returns the parser to the file-header phase and empties the queue.
module string_table_stream_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  stsp_pkg::stsp_req_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output stsp_pkg::stsp_rsp_type rsp_item
);
   import stsp_pkg::*;

   stsp_group_type group;
   logic           full;
   logic           accept;

   // An item is taken whenever the queue has a free group slot; this does
   // not wait for the response side, so bytes that cause no result (header
   // words, skipped extra data) flow at one per cycle.
   assign req_stall = full;
   assign accept    = req_valid & ~full;

   // The parser holds the whole file state and turns the accepted item into
   // its group of results in the same cycle.
   stsp_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .item   (req_item),
      .group  (group)
   );

   // Groups with no results are not queued, so they never cost an output
   // cycle.
   stsp_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && group.count != 3'd0),
      .group     (group),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

>>> test/string_table_stream_parser_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for string_table_stream_parser: a short table of directed bytes,
// then generated string-table files, checked against the table or the parser model here.
// Depends on stsp_pkg and the parser RTL; drives both channels with random idling.
module string_table_stream_parser_tb;
   import stsp_pkg::*;

   // Run sizes and pacing. No new file starts once this many random items have gone in.
   localparam int RANDOM_ITEMS = 500;
   localparam int IDLE_PERCENT = 19;
   // The receiver holds off once for this many cycles after HOLD_AT items have gone in,
   // so that the result queue fills and the parser has to stall its input.
   localparam int HOLD_AT      = 150;
   localparam int HOLD_CYCLES  = 120;
   // Between these item counts neither side idles at all.
   localparam int CALM_FROM    = 300;
   localparam int CALM_TO      = 420;
   // An item causes at most five results, so a short drain is plenty.
   localparam int DRAIN_CYCLES = 20;
   // Cycles with no item moving on either channel before the run is abandoned.
   localparam int QUIET_LIMIT  = 2000;

   // Shapes of generated file.
   typedef enum int {
      SHAPE_CLEAN,
      SHAPE_CUT,
      SHAPE_BAD_FILE,
      SHAPE_BAD_LABEL,
      SHAPE_BAD_MARKER,
      SHAPE_EMPTY,
      SHAPE_NOISE
   } file_shape_type;

   // One row of the directed table. Where typed is set, the single status result that the
   // row causes is written in the table; otherwise the model decides.
   typedef struct packed {
      logic [7:0] data;
      logic       eof;
      logic       typed;
      logic [2:0] status;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 26;

   logic         clock;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   stsp_req_type req_item  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   stsp_rsp_type rsp_item;

   // Results still owed by the parser, oldest first, and those of the byte being modelled.
   stsp_rsp_type parsed_results[$];
   stsp_rsp_type step_out[$];
   logic [7:0]   file_bytes[$];

   int   items_sent     = 0;
   int   results_seen   = 0;
   int   mismatch_count = 0;
   int   quiet_cycles   = 0;
   logic calm;
   logic hold_done      = 1'b0;

   // Model state of the parser.
   logic [3:0]  ph;
   logic [4:0]  hdr_idx;
   logic        unit_half;
   logic [31:0] shift_word;
   logic [31:0] labels_todo;
   logic [31:0] pairs_todo;
   logic [31:0] bytes_todo;
   logic [7:0]  unit_low;
   logic        pair_wide;
   logic        text_done;
   logic        name_done_any;
   logic [2:0]  fault;

   stim_row_type dir_rows [0:DIRECTED_ROWS-1];

   assign calm = (items_sent >= CALM_FROM) && (items_sent < CALM_TO);

   string_table_stream_parser u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------------------------
   // Parser model
   // ------------------------------------------------------------------------------------

   task automatic clear_parse_state();
      ph            = PH_FILE;
      hdr_idx       = '0;
      unit_half     = 1'b0;
      shift_word    = '0;
      labels_todo   = '0;
      pairs_todo    = '0;
      bytes_todo    = '0;
      unit_low      = '0;
      pair_wide     = 1'b0;
      text_done     = 1'b0;
      name_done_any = 1'b0;
      fault         = ST_OK;
   endtask

   task automatic add_result(input logic [2:0] kind, input logic [7:0] data,
                             input logic [2:0] status);
      stsp_rsp_type r;
      r.out_kind    = kind;
      r.out_byte    = data;
      r.file_status = status;
      r.last_of_run = 1'b0;
      step_out.insert(step_out.size(), r);
   endtask

   // The last label done means anything after it is trailing padding.
   task automatic close_label();
      labels_todo = labels_todo - 1;
      hdr_idx     = '0;
      ph          = (labels_todo == 0) ? PH_TAIL : PH_LABEL;
   endtask

   task automatic close_pair();
      pairs_todo = pairs_todo - 1;
      hdr_idx    = '0;
      if (pairs_todo == 0) begin
         close_label();
      end else begin
         ph = PH_PAIR;
      end
   endtask

   task automatic close_name();
      add_result(KIND_NAME_END, 8'h00, ST_OK);
      name_done_any = 1'b1;
      hdr_idx       = '0;
      if (pairs_todo == 0) begin
         close_label();
      end else begin
         ph = PH_PAIR;
      end
   endtask

   // A wide pair still carries its length word and extra block after the text.
   task automatic close_text();
      add_result(KIND_VALUE_END, 8'h00, ST_OK);
      hdr_idx = '0;
      if (pair_wide) begin
         ph = PH_XLEN;
      end else begin
         close_pair();
      end
   endtask

   // Works out every result that one input byte causes and leaves them in step_out.
   task automatic parse_byte(input logic [7:0] b, input logic eof);
      logic [15:0] cp;
      logic [2:0]  st;
      step_out.delete();
      case (ph)
         PH_FILE: begin
            shift_word = {b, shift_word[31:8]};
            // Bytes 0 to 3 are the magic, bytes 8 to 11 the label count.
            if (hdr_idx == 5'd3 && shift_word != FILE_MAGIC) fault = ST_BAD_FILE;
            if (hdr_idx == 5'd11) labels_todo = shift_word;
            if (hdr_idx == FILE_HDR_LAST) begin
               hdr_idx = '0;
               if (fault != ST_OK) begin
                  ph = PH_ERR;
               end else begin
                  ph = (labels_todo == 0) ? PH_TAIL : PH_LABEL;
               end
            end else begin
               hdr_idx++;
            end
         end
         PH_LABEL: begin
            shift_word = {b, shift_word[31:8]};
            if (hdr_idx == 5'd3 && shift_word != LABEL_MAGIC && fault == ST_OK) begin
               fault = ST_BAD_LABEL;
            end
            if (hdr_idx == 5'd7) pairs_todo = shift_word;
            if (hdr_idx == 5'd11) begin
               bytes_todo = shift_word;
               hdr_idx    = '0;
               if (fault != ST_OK) begin
                  ph = PH_ERR;
               end else begin
                  text_done = 1'b0;
                  if (bytes_todo == 0) begin
                     close_name();
                  end else begin
                     ph = PH_NAME;
                  end
               end
            end else begin
               hdr_idx++;
            end
         end
         PH_NAME: begin
            if (!text_done) begin
               if (b == 8'h00) begin
                  text_done = 1'b1;
               end else begin
                  add_result(KIND_NAME_BYTE,
                             (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b, ST_OK);
               end
            end
            bytes_todo = bytes_todo - 1;
            if (bytes_todo == 0) close_name();
         end
         PH_PAIR: begin
            shift_word = {b, shift_word[31:8]};
            if (hdr_idx == 5'd3) begin
               if (shift_word == MARK_PLAIN) begin
                  pair_wide = 1'b0;
               end else if (shift_word == MARK_WIDE) begin
                  pair_wide = 1'b1;
               end else if (fault == ST_OK) begin
                  fault = ST_BAD_MARKER;
               end
            end
            if (hdr_idx == 5'd7) begin
               bytes_todo = shift_word;
               hdr_idx    = '0;
               if (fault != ST_OK) begin
                  ph = PH_ERR;
               end else begin
                  text_done = 1'b0;
                  unit_half = 1'b0;
                  if (bytes_todo == 0) begin
                     close_text();
                  end else begin
                     ph = PH_TEXT;
                  end
               end
            end else begin
               hdr_idx++;
            end
         end
         PH_TEXT: begin
            if (!unit_half) begin
               unit_low  = b;
               unit_half = 1'b1;
            end else begin
               unit_half = 1'b0;
               if (!text_done) begin
                  // Units are stored inverted; a zero unit ends the text early.
                  cp = ~{b, unit_low};
                  if (cp == 16'h0000) begin
                     text_done = 1'b1;
                  end else if (cp < 16'h0080) begin
                     add_result(KIND_VALUE_BYTE, cp[7:0], ST_OK);
                  end else if (cp < 16'h0800) begin
                     add_result(KIND_VALUE_BYTE, {3'b110, cp[10:6]}, ST_OK);
                     add_result(KIND_VALUE_BYTE, {2'b10, cp[5:0]}, ST_OK);
                  end else begin
                     add_result(KIND_VALUE_BYTE, {4'b1110, cp[15:12]}, ST_OK);
                     add_result(KIND_VALUE_BYTE, {2'b10, cp[11:6]}, ST_OK);
                     add_result(KIND_VALUE_BYTE, {2'b10, cp[5:0]}, ST_OK);
                  end
               end
               bytes_todo = bytes_todo - 1;
               if (bytes_todo == 0) close_text();
            end
         end
         PH_XLEN: begin
            shift_word = {b, shift_word[31:8]};
            if (hdr_idx == 5'd3) begin
               bytes_todo = shift_word;
               hdr_idx    = '0;
               if (bytes_todo == 0) begin
                  close_pair();
               end else begin
                  ph = PH_XTRA;
               end
            end else begin
               hdr_idx++;
            end
         end
         PH_XTRA: begin
            bytes_todo = bytes_todo - 1;
            if (bytes_todo == 0) close_pair();
         end
         default: begin
         end
      endcase
      if (eof) begin
         if (ph == PH_ERR) begin
            st = fault;
         end else if (ph == PH_FILE) begin
            st = ST_SHORT_HDR;
         end else if (ph inside {PH_NAME, PH_TEXT, PH_XLEN, PH_XTRA}) begin
            st = ST_TRUNCATED;
         end else begin
            st = name_done_any ? ST_OK : ST_NO_LABELS;
         end
         add_result(KIND_STATUS, 8'h00, st);
         clear_parse_state();
      end
      if (step_out.size() != 0) step_out[step_out.size() - 1].last_of_run = 1'b1;
   endtask

   // ------------------------------------------------------------------------------------
   // File generation
   // ------------------------------------------------------------------------------------

   task automatic add_byte(input logic [7:0] v);
      file_bytes.insert(file_bytes.size(), v);
   endtask

   task automatic add_word(input logic [31:0] w);
      add_byte(w[7:0]);
      add_byte(w[15:8]);
      add_byte(w[23:16]);
      add_byte(w[31:24]);
   endtask

   // Builds one string-table file of the given shape in file_bytes. Sizes are kept small
   // so that many files, and so many ends and faults, fit into the run.
   task automatic build_file(input file_shape_type shape);
      int          n_labels;
      int          n_pairs;
      int          n_name;
      int          n_units;
      int          n_extra;
      int          i;
      int          j;
      int          k;
      logic [31:0] word;
      logic [15:0] cp;
      logic [15:0] raw;
      logic        wide;
      logic        marker_fault;
      logic [7:0]  nb;
      file_bytes.delete();
      if (shape == SHAPE_NOISE) begin
         n_extra = $urandom_range(1, 40);
         for (i = 0; i < n_extra; i++) add_byte(8'($urandom_range(0, 255)));
         return;
      end
      n_labels = (shape == SHAPE_EMPTY) ? 0 : $urandom_range(1, 2);
      // Now and then the label count disagrees with what follows: too many labels leave
      // the file ending in a label header, too few turn the last label into trailing bytes.
      case ($urandom_range(0, 9))
         0:       word = n_labels + 1;
         1:       word = n_labels - 1;
         default: word = n_labels;
      endcase
      add_word((shape == SHAPE_BAD_FILE) ? FILE_MAGIC ^ (32'h1 << $urandom_range(0, 31))
                                         : FILE_MAGIC);
      add_word($urandom);
      add_word(word);
      for (i = 0; i < 3; i++) add_word($urandom);
      marker_fault = (shape == SHAPE_BAD_MARKER);
      for (i = 0; i < n_labels; i++) begin
         if (shape == SHAPE_BAD_LABEL && i == n_labels - 1) begin
            add_word(LABEL_MAGIC ^ (32'h1 << $urandom_range(0, 31)));
         end else begin
            add_word(LABEL_MAGIC);
         end
         n_pairs = $urandom_range(0, 2);
         n_name  = $urandom_range(0, 5);
         add_word(n_pairs);
         add_word(n_name);
         // Names are mostly letters of both cases, with the characters just outside the
         // upper-case range, zero bytes that stop the name early, and random bytes.
         for (k = 0; k < n_name; k++) begin
            case ($urandom_range(0, 7))
               0:       nb = 8'h00;
               1, 2, 3: nb = 8'h41 + 8'($urandom_range(0, 25));
               4, 5:    nb = 8'h61 + 8'($urandom_range(0, 25));
               6:       nb = 8'($urandom_range(0, 255));
               default: nb = $urandom_range(0, 1) ? 8'h40 : 8'h5B;
            endcase
            add_byte(nb);
         end
         for (j = 0; j < n_pairs; j++) begin
            wide = ($urandom_range(0, 2) == 0);
            word = wide ? MARK_WIDE : MARK_PLAIN;
            if (marker_fault) begin
               word         = word ^ (32'h1 << $urandom_range(0, 31));
               marker_fault = 1'b0;
            end
            add_word(word);
            n_units = $urandom_range(0, 3);
            add_word(n_units);
            for (k = 0; k < n_units; k++) begin
               case ($urandom_range(0, 9))
                  0:       cp = 16'h0000;
                  1, 2, 3: cp = 16'($urandom_range(16'h0001, 16'h007F));
                  4, 5:    cp = 16'($urandom_range(16'h0080, 16'h07FF));
                  6, 7:    cp = 16'($urandom_range(16'h0800, 16'hFFFF));
                  8:       cp = 16'($urandom_range(16'hD800, 16'hDFFF));
                  default: begin
                     case ($urandom_range(0, 4))
                        0:       cp = 16'h007F;
                        1:       cp = 16'h0080;
                        2:       cp = 16'h07FF;
                        3:       cp = 16'h0800;
                        default: cp = 16'hFFFF;
                     endcase
                  end
               endcase
               raw = ~cp;
               add_byte(raw[7:0]);
               add_byte(raw[15:8]);
            end
            if (wide) begin
               n_extra = $urandom_range(0, 3);
               add_word(n_extra);
               for (k = 0; k < n_extra; k++) add_byte(8'($urandom_range(0, 255)));
            end
         end
      end
      n_extra = $urandom_range(0, 3);
      for (k = 0; k < n_extra; k++) add_byte(8'($urandom_range(0, 255)));
   endtask

   // ------------------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------------------

   // Offers one item, idling now and then beforehand, and once it is taken records the
   // results it owes: the typed status where the row gives one, the model's otherwise.
   task automatic offer(input logic [7:0] data, input logic eof, input logic typed,
                        input logic [2:0] status);
      stsp_req_type it;
      stsp_rsp_type r;
      it.data_byte   = data;
      it.end_of_file = eof;
      while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (req_stall);
      items_sent++;
      parse_byte(data, eof);
      if (typed) begin
         r             = '0;
         r.out_kind    = KIND_STATUS;
         r.file_status = status;
         r.last_of_run = 1'b1;
         parsed_results.insert(parsed_results.size(), r);
      end else begin
         foreach (step_out[i]) parsed_results.insert(parsed_results.size(), step_out[i]);
      end
   endtask

   initial begin
      file_shape_type shape;
      int             file_idx;
      int             cut;
      int             i;
      // The directed part: a one-byte file of each extreme byte value, which ends inside
      // the file header, then a complete header with a label count of zero, ending on its
      // last byte. The header bytes between take every bit both ways.
      dir_rows = '{
         '{8'h00, 1'b1, 1'b1, ST_SHORT_HDR},
         '{8'hFF, 1'b1, 1'b1, ST_SHORT_HDR},
         '{8'h20, 1'b0, 1'b0, ST_OK}, '{8'h46, 1'b0, 1'b0, ST_OK},
         '{8'h53, 1'b0, 1'b0, ST_OK}, '{8'h43, 1'b0, 1'b0, ST_OK},
         '{8'hFF, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK},
         '{8'h80, 1'b0, 1'b0, ST_OK}, '{8'h7F, 1'b0, 1'b0, ST_OK},
         '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK},
         '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK},
         '{8'h01, 1'b0, 1'b0, ST_OK}, '{8'h02, 1'b0, 1'b0, ST_OK},
         '{8'h04, 1'b0, 1'b0, ST_OK}, '{8'h08, 1'b0, 1'b0, ST_OK},
         '{8'h10, 1'b0, 1'b0, ST_OK}, '{8'h20, 1'b0, 1'b0, ST_OK},
         '{8'h40, 1'b0, 1'b0, ST_OK}, '{8'h80, 1'b0, 1'b0, ST_OK},
         '{8'hFE, 1'b0, 1'b0, ST_OK}, '{8'hFD, 1'b0, 1'b0, ST_OK},
         '{8'hFB, 1'b0, 1'b0, ST_OK},
         '{8'hF7, 1'b1, 1'b1, ST_NO_LABELS}
      };
      clear_parse_state();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < DIRECTED_ROWS; i++) begin
         offer(dir_rows[i].data, dir_rows[i].eof, dir_rows[i].typed, dir_rows[i].status);
      end

      // The random part: the first files go through every shape once, after which clean
      // and cut-short files make up most of the mix. A cut-short file ends at a random
      // byte, so ends fall inside every part of the format.
      file_idx = 0;
      while (items_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
         if (file_idx <= int'(SHAPE_NOISE)) begin
            shape = file_shape_type'(file_idx);
         end else begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: shape = SHAPE_CLEAN;
               4, 5:       shape = SHAPE_CUT;
               6:          shape = SHAPE_BAD_FILE;
               7:          shape = SHAPE_BAD_LABEL;
               8:          shape = SHAPE_BAD_MARKER;
               default:    shape = ($urandom_range(0, 1) != 0) ? SHAPE_NOISE : SHAPE_EMPTY;
            endcase
         end
         build_file(shape);
         cut = file_bytes.size();
         if (shape == SHAPE_CUT) cut = $urandom_range(1, file_bytes.size());
         for (i = 0; i < cut; i++) offer(file_bytes[i], i == cut - 1, 1'b0, ST_OK);
         file_idx++;
      end
      req_valid <= 1'b0;

      // Wait for every owed result, then a little longer to catch any extra ones.
      while (parsed_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("string_table_stream_parser_tb: PASS");
      end else begin
         $display("string_table_stream_parser_tb: FAIL");
      end
      $finish;
   end

   // ------------------------------------------------------------------------------------
   // Result side
   // ------------------------------------------------------------------------------------

   // The receiver stalls at random, not at all in the calm stretch, and once holds off for
   // a long stretch while the sender keeps offering items.
   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (items_sent >= HOLD_AT && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
            @(posedge clock);
         end
      end
   end

   // Prints one line per mismatch and counts every one.
   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("mismatch on result %0d: %s", results_seen, what);
   endtask

   // Checks each accepted result against the oldest one owed, and keeps the watchdog.
   always @(posedge clock) begin
      stsp_rsp_type want;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("string_table_stream_parser_tb: FAIL");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (parsed_results.size() == 0) begin
            report_mismatch($sformatf("result kind %0d with nothing owed", rsp_item.out_kind));
         end else begin
            want = parsed_results.pop_front();
            if (rsp_item.out_kind !== want.out_kind) begin
               report_mismatch($sformatf("out_kind %0d, want %0d",
                                         rsp_item.out_kind, want.out_kind));
            end
            if (rsp_item.out_byte !== want.out_byte) begin
               report_mismatch($sformatf("out_byte %h, want %h",
                                         rsp_item.out_byte, want.out_byte));
            end
            if (rsp_item.file_status !== want.file_status) begin
               report_mismatch($sformatf("file_status %0d, want %0d",
                                         rsp_item.file_status, want.file_status));
            end
            if (rsp_item.last_of_run !== want.last_of_run) begin
               report_mismatch($sformatf("last_of_run %b, want %b",
                                         rsp_item.last_of_run, want.last_of_run));
            end
         end
      end
   end

endmodule
